// ----- hdl/enigma_pkg.sv -----
// types, wiring tables and mod-26 helpers for the three-rotor cipher
`default_nettype none
package enigma_pkg;

	localparam int ALPHA = 26;
	localparam int LAST_POS = 25;

	typedef logic [4:0] letter_t;

	typedef struct packed {
		letter_t left;
		letter_t middle;
		letter_t right;
	} rotor_pos_t;

	localparam logic CMD_ENCIPHER = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// forward wirings, index = input contact
	localparam letter_t WIRE_RIGHT [ALPHA] = '{
		5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25,
		5'd13, 5'd19, 5'd14, 5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15,
		5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9};
	localparam letter_t WIRE_MIDDLE [ALPHA] = '{
		5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1,
		5'd11, 5'd7, 5'd22, 5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13,
		5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4};
	localparam letter_t WIRE_LEFT [ALPHA] = '{
		5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19,
		5'd23, 5'd21, 5'd25, 5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0,
		5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};

	// inverse wirings, index = output contact
	localparam letter_t INV_RIGHT [ALPHA] = '{
		5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25,
		5'd1, 5'd4, 5'd2, 5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11,
		5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9};
	localparam letter_t INV_MIDDLE [ALPHA] = '{
		5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1,
		5'd3, 5'd10, 5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13,
		5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18};
	localparam letter_t INV_LEFT [ALPHA] = '{
		5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4,
		5'd20, 5'd5, 5'd21, 5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9,
		5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};

	localparam letter_t WIRE_PLUG [ALPHA] = '{
		5'd2, 5'd23, 5'd0, 5'd6, 5'd11, 5'd12, 5'd3, 5'd7, 5'd13, 5'd9,
		5'd20, 5'd4, 5'd5, 5'd8, 5'd18, 5'd21, 5'd16, 5'd17, 5'd14, 5'd24,
		5'd10, 5'd15, 5'd25, 5'd1, 5'd19, 5'd22};
	localparam letter_t WIRE_REFL [ALPHA] = '{
		5'd12, 5'd2, 5'd1, 5'd24, 5'd19, 5'd14, 5'd16, 5'd21, 5'd8, 5'd9,
		5'd10, 5'd11, 5'd0, 5'd15, 5'd5, 5'd13, 5'd6, 5'd22, 5'd20, 5'd4,
		5'd18, 5'd7, 5'd17, 5'd25, 5'd3, 5'd23};

	// fold a 5-bit value into 0..25
	function automatic letter_t reduce26(input letter_t v);
		reduce26 = (v >= letter_t'(ALPHA)) ? letter_t'(v - letter_t'(ALPHA)) : v;
	endfunction

	// (a + b) mod 26 for a, b in 0..25
	function automatic letter_t add26(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		add26 = (s >= 6'(ALPHA)) ? letter_t'(s - 6'(ALPHA)) : letter_t'(s);
	endfunction

	// (a - b) mod 26 for a, b in 0..25
	function automatic letter_t sub26(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + 6'(ALPHA) - {1'b0, b};
		sub26 = (s >= 6'(ALPHA)) ? letter_t'(s - 6'(ALPHA)) : letter_t'(s);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/enigma_path.sv -----
// combinational letter path: plugboard, rotors, reflector and back
`default_nettype none
module enigma_path import enigma_pkg::*; (
	input  wire letter_t    letter,
	input  wire rotor_pos_t pos,
	output letter_t         cipher
);

	letter_t p0, r0, m0, l0, rf, l1, m1, r1;

	always_comb begin
		p0 = WIRE_PLUG[letter];
		r0 = WIRE_RIGHT[add26(p0, pos.right)];
		m0 = WIRE_MIDDLE[add26(r0, pos.middle)];
		l0 = WIRE_LEFT[add26(m0, pos.left)];
		rf = WIRE_REFL[l0];
		l1 = sub26(INV_LEFT[rf], pos.left);
		m1 = sub26(INV_MIDDLE[l1], pos.middle);
		r1 = sub26(INV_RIGHT[m1], pos.right);
		cipher = WIRE_PLUG[r1];
	end

endmodule
`default_nettype wire

// ----- hdl/three_rotor_enigma_cipher.sv -----
// top level of the three-rotor letter cipher
// usage:
//   item channel takes one item_valid beat a cycle while item_stall is low.
//   command encipher: letter (0..25, 26..31 fold to 0..25) is enciphered
//   with the current rotor positions, then the rotors step like an odometer.
//   command load: start_left/middle/right become the positions; no result.
//   result channel (result_valid / result_stall) returns cipher_letter.
// order: an accepted letter is captured in the input register, passes the
//   rotor path and is registered in the result register, which drives the
//   result port; loads take effect for the very next beat.
// throughput: one beat per cycle unless stalled, set by the single pass
//   through the rotor path between the input and the result register.
// stall: while result_stall holds a waiting result, one more letter may sit
//   in the input register; only then is item_stall raised.
// reset: positions go to left 1, middle 2, right 4; both registers empty.
`default_nettype none
module three_rotor_enigma_cipher import enigma_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       item_valid,
	output logic      item_stall,
	input  wire       command,
	input  wire [4:0] letter,
	input  wire [4:0] start_left,
	input  wire [4:0] start_middle,
	input  wire [4:0] start_right,
	output logic      result_valid,
	input  wire       result_stall,
	output logic [4:0] cipher_letter
);

	// architectural rotor positions, raw as loaded
	rotor_pos_t pos_q;

	// input register: letter and positions (folded) used for it
	logic       valid_s1;
	letter_t    letter_s1;
	rotor_pos_t pos_s1;

	logic       result_valid_q;
	letter_t    cipher_q;

	logic       out_free;
	logic       item_acc;
	letter_t    cipher_comb;
	rotor_pos_t pos_next;
	logic       carry_r, carry_m;

	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !out_free;
	assign item_acc   = item_valid && !item_stall;

	// odometer step; anything at 25 or above wraps and carries
	always_comb begin
		carry_r = pos_q.right >= letter_t'(LAST_POS);
		carry_m = pos_q.middle >= letter_t'(LAST_POS);
		pos_next = pos_q;
		if (carry_r) begin
			pos_next.right = '0;
			if (carry_m) begin
				pos_next.middle = '0;
				pos_next.left = (pos_q.left >= letter_t'(LAST_POS)) ? '0
					: letter_t'(pos_q.left + 5'd1);
			end else begin
				pos_next.middle = letter_t'(pos_q.middle + 5'd1);
			end
		end else begin
			pos_next.right = letter_t'(pos_q.right + 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q.left   <= 5'd1;
			pos_q.middle <= 5'd2;
			pos_q.right  <= 5'd4;
		end else if (item_acc) begin
			if (command == CMD_LOAD) begin
				pos_q.left   <= start_left;
				pos_q.middle <= start_middle;
				pos_q.right  <= start_right;
			end else begin
				pos_q <= pos_next;
			end
		end
	end

	// input register advances whenever it is empty or the result register can move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_acc && (command == CMD_ENCIPHER);
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc && (command == CMD_ENCIPHER)) begin
			letter_s1     <= reduce26(letter);
			pos_s1.left   <= reduce26(pos_q.left);
			pos_s1.middle <= reduce26(pos_q.middle);
			pos_s1.right  <= reduce26(pos_q.right);
		end
	end

	enigma_path u_path (
		.letter (letter_s1),
		.pos    (pos_s1),
		.cipher (cipher_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			cipher_q <= cipher_comb;
		end
	end

	assign result_valid  = result_valid_q;
	assign cipher_letter = cipher_q;

`ifndef SYNTH
	// a stalled result beat stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |=> (result_valid_q && $stable(cipher_q)))
		else $error("stalled result changed");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (cipher_q < letter_t'(ALPHA)))
		else $error("cipher letter out of range");

	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && command == CMD_LOAD) |=>
		(pos_q.left == $past(start_left) && pos_q.middle == $past(start_middle)
		&& pos_q.right == $past(start_right)))
		else $error("load did not set rotor positions");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && command == CMD_LOAD) |=> !valid_s1)
		else $error("load produced a result");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid_q && result_stall))
		else $error("stall raised with room available");
`endif

endmodule
`default_nettype wire

// ----- verif/three_rotor_enigma_cipher_test.sv -----
// self-checking testbench for the three-rotor letter cipher: plan, random beats, scoreboard
`default_nettype none
module three_rotor_enigma_cipher_test import enigma_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// wirings as letter strings, first character in the top byte
	typedef bit [8*ALPHA-1:0] wiring_t;

	localparam wiring_t ROTOR_RIGHT  = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
	localparam wiring_t ROTOR_MIDDLE = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
	localparam wiring_t ROTOR_LEFT   = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
	localparam wiring_t PLUGBOARD    = "CXAGLMDHNJUEFISVQROYKPZBTW";
	localparam wiring_t REFLECTOR    = "MCBYTOQVIJKLAPFNGWUESHRZDX";
	localparam int CHAR_A = 65;

	localparam int RANDOM_BEATS = 1428;
	localparam int DRAIN_EVERY = 350;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 12;

	// one row of the opening plan; typed rows carry a hand-worked cipher letter
	typedef struct packed {
		logic    cmd;
		letter_t ltr;
		letter_t sl;
		letter_t sm;
		letter_t sr;
		bit      typed;
		letter_t want;
	} plan_row_t;

	localparam int PLAN_LEN = 22;
	localparam plan_row_t OPENING_PLAN [PLAN_LEN] = '{
		// reset positions 1/2/4: A goes to J
		'{CMD_ENCIPHER, 5'd0,  5'd0,  5'd0,  5'd0,  1'b1, 5'd9},
		// back to 1/2/4: the cipher is its own inverse, so J returns A
		'{CMD_LOAD,     5'd0,  5'd1,  5'd2,  5'd4,  1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd9,  5'd0,  5'd0,  5'd0,  1'b1, 5'd0},
		// all rotors at zero, letter extremes
		'{CMD_LOAD,     5'd0,  5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd25, 5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd0,  5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		// one step short of the double carry, then carry through all three
		'{CMD_LOAD,     5'd0,  5'd25, 5'd25, 5'd24, 1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd31, 5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd26, 5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd13, 5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		// positions above 25 are kept, used mod 26 and wrap on the step
		'{CMD_LOAD,     5'd0,  5'd31, 5'd31, 5'd31, 1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd30, 5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd0,  5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		'{CMD_LOAD,     5'd0,  5'd26, 5'd27, 5'd28, 1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd25, 5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd7,  5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		// middle carries into left
		'{CMD_LOAD,     5'd0,  5'd0,  5'd25, 5'd25, 1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd1,  5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd2,  5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		// right wraps, middle absorbs the carry, left stays at 25
		'{CMD_LOAD,     5'd0,  5'd25, 5'd0,  5'd25, 1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd24, 5'd0,  5'd0,  5'd0,  1'b0, 5'd0},
		'{CMD_ENCIPHER, 5'd17, 5'd0,  5'd0,  5'd0,  1'b0, 5'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// item channel, driven by the sender
	logic    item_valid = 1'b0;
	logic    item_stall;
	logic    command = CMD_ENCIPHER;
	letter_t letter = '0;
	letter_t start_left = '0;
	letter_t start_middle = '0;
	letter_t start_right = '0;

	// result channel
	logic    result_valid;
	logic    result_stall = 1'b0;
	letter_t cipher_letter;

	// rotor positions as the block should hold them
	letter_t pos_left;
	letter_t pos_middle;
	letter_t pos_right;

	// cipher letters still owed by the block, oldest first
	letter_t pending_cipher [$];

	int faults = 0;
	int idle_cycles = 0;

	three_rotor_enigma_cipher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.letter       (letter),
		.start_left   (start_left),
		.start_middle (start_middle),
		.start_right  (start_right),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cipher_letter(cipher_letter)
	);

	always #4 clk = ~clk;

	// contact i of a wiring, as a letter index
	function automatic int wiring_at(input wiring_t w, input int i);
		return int'(w[8*(ALPHA-1-i) +: 8]) - CHAR_A;
	endfunction

	// forward pass through a rotor at the given position
	function automatic int rotor_in(input wiring_t w, input int v, input letter_t pos);
		return wiring_at(w, (v + int'(pos) % ALPHA) % ALPHA);
	endfunction

	// return pass: find the contact that carries v, then undo the offset
	function automatic int rotor_back(input wiring_t w, input int v, input letter_t pos);
		int at;
		at = 0;
		for (int i = 0; i < ALPHA; i++) begin
			if (wiring_at(w, i) == v) at = i;
		end
		return (at + ALPHA - int'(pos) % ALPHA) % ALPHA;
	endfunction

	// cipher letter for one plaintext beat, then the odometer step
	function automatic letter_t rotor_cipher(input letter_t plain);
		int v;
		v = int'(plain) % ALPHA;
		v = wiring_at(PLUGBOARD, v);
		v = rotor_in(ROTOR_RIGHT, v, pos_right);
		v = rotor_in(ROTOR_MIDDLE, v, pos_middle);
		v = rotor_in(ROTOR_LEFT, v, pos_left);
		v = wiring_at(REFLECTOR, v);
		v = rotor_back(ROTOR_LEFT, v, pos_left);
		v = rotor_back(ROTOR_MIDDLE, v, pos_middle);
		v = rotor_back(ROTOR_RIGHT, v, pos_right);
		v = wiring_at(PLUGBOARD, v);
		// any position at or past 25 wraps to zero and carries
		if (pos_right >= letter_t'(LAST_POS)) begin
			pos_right = '0;
			if (pos_middle >= letter_t'(LAST_POS)) begin
				pos_middle = '0;
				if (pos_left >= letter_t'(LAST_POS)) pos_left = '0;
				else pos_left = pos_left + 1'b1;
			end else begin
				pos_middle = pos_middle + 1'b1;
			end
		end else begin
			pos_right = pos_right + 1'b1;
		end
		return letter_t'(v);
	endfunction

	// mostly legal positions, leaning toward the carry points, now and then 26..31
	function automatic letter_t pick_position();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return letter_t'($urandom_range(26, 31));
		if (r <= 6) return letter_t'($urandom_range(23, 25));
		return letter_t'($urandom_range(0, 25));
	endfunction

	task automatic note_mismatch(input string msg);
		faults++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// offer one beat after a random gap; on acceptance update the model state
	// and queue the cipher letter that is owed. hold waits for the queue to empty first.
	task automatic send_beat(input logic cmd, input letter_t ltr, input letter_t sl,
			input letter_t sm, input letter_t sr, input bit typed, input letter_t want,
			input bit hold);
		int gap;
		int r;
		letter_t got;
		r = $urandom_range(0, 99);
		if (r < 55) gap = 0;
		else if (r < 92) gap = $urandom_range(1, 3);
		else gap = $urandom_range(8, 40);
		// valid has to drop before the drain wait
		if (hold && gap == 0) gap = 1;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (hold) begin
			while (pending_cipher.size() != 0) @(posedge clk);
		end
		command <= cmd;
		letter <= ltr;
		start_left <= sl;
		start_middle <= sm;
		start_right <= sr;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (cmd == CMD_LOAD) begin
			pos_left = sl;
			pos_middle = sm;
			pos_right = sr;
		end else begin
			got = rotor_cipher(ltr);
			pending_cipher.push_back(typed ? want : got);
		end
	endtask

	// receiver: free runs and stalls of random length, a few of them long
	initial begin
		int free_n;
		int stall_n;
		forever begin
			free_n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 6);
			repeat (free_n) @(posedge clk);
			result_stall <= 1'b1;
			stall_n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 3);
			repeat (stall_n) @(posedge clk);
			result_stall <= 1'b0;
		end
	end

	// scoreboard: every result beat is matched against the oldest owed letter
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_cipher.size() == 0) begin
				note_mismatch($sformatf("cipher_letter %0d with nothing owed", cipher_letter));
			end else begin
				letter_t want;
				want = pending_cipher.pop_front();
				if (cipher_letter !== want)
					note_mismatch($sformatf("cipher_letter %0d, expected %0d",
						cipher_letter, want));
			end
		end
	end

	// watchdog: too many cycles in a row with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// stimulus: reset, opening plan, random beats, drain, verdict
	initial begin
		int roll;
		bit hold;
		logic cmd;
		letter_t ltr;
		letter_t sl;
		letter_t sm;
		letter_t sr;

		pos_left = 5'd1;
		pos_middle = 5'd2;
		pos_right = 5'd4;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (OPENING_PLAN[i])
			send_beat(OPENING_PLAN[i].cmd, OPENING_PLAN[i].ltr, OPENING_PLAN[i].sl,
				OPENING_PLAN[i].sm, OPENING_PLAN[i].sr, OPENING_PLAN[i].typed,
				OPENING_PLAN[i].want, 1'b0);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			roll = $urandom_range(0, 99);
			// let the pipe run dry now and then, first right after the plan
			hold = (n % DRAIN_EVERY == 0);
			sl = letter_t'($urandom_range(0, 31));
			sm = letter_t'($urandom_range(0, 31));
			sr = letter_t'($urandom_range(0, 31));
			if (roll < 10) begin
				cmd = CMD_LOAD;
				ltr = letter_t'($urandom_range(0, 31));
				sl = pick_position();
				sm = pick_position();
				sr = pick_position();
			end else begin
				cmd = CMD_ENCIPHER;
				// letters 26..31 fold back onto A..F
				ltr = ($urandom_range(0, 19) == 0) ? letter_t'($urandom_range(26, 31))
					: letter_t'($urandom_range(0, 25));
			end
			send_beat(cmd, ltr, sl, sm, sr, 1'b0, '0, hold);
		end
		item_valid <= 1'b0;

		// wait out the owed letters, then watch for anything stray
		while (pending_cipher.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (faults == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
